// ===== sv/bcd_pkg.sv =====
// Package for the blink code decoder: item, configuration and state types,
// register indexes, status bit masks and timer constants.
// No dependencies.
`default_nettype none

package bcd_pkg;

    // Timer width for elapsed and since_dark counters (12 to 32)
    localparam int TIMER_BITS = 16;
    localparam longint unsigned TIMER_MAX = (64'd1 << TIMER_BITS) - 64'd1;

    localparam int THR_BITS   = 10;
    localparam int GAP_BITS   = 16;
    localparam int COUNT_BITS = 8;
    localparam int STAT_BITS  = 4;
    localparam int CFG_BITS   = 16;
    localparam int IDX_BITS   = 3;

    // Minimum spacing between two taken dark samples
    localparam logic [TIMER_BITS-1:0] DARK_SPACING = TIMER_BITS'(2);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX    = '1;

    // Status bits
    localparam logic [STAT_BITS-1:0] ST_BASE  = 4'h1;
    localparam logic [STAT_BITS-1:0] ST_DARK  = 4'h2;
    localparam logic [STAT_BITS-1:0] ST_COUNT = 4'h4;
    localparam logic [STAT_BITS-1:0] ST_BLINK = 4'h8;

    // Configuration register indexes
    typedef enum logic [IDX_BITS-1:0] {
        CFG_DARK_THRESHOLD = 3'd0,
        CFG_BLINK_GAP_MIN  = 3'd1,
        CFG_BLINK_GAP_MAX  = 3'd2,
        CFG_CODE_GAP_MIN   = 3'd3,
        CFG_CODE_GAP_MAX   = 3'd4,
        CFG_WINDOW_TICKS   = 3'd5
    } t_cfg_idx;

    // Reset values of the configuration registers
    localparam logic [THR_BITS-1:0] RST_DARK_THRESHOLD = 10'd60;
    localparam logic [GAP_BITS-1:0] RST_BLINK_GAP_MIN  = 16'd700;
    localparam logic [GAP_BITS-1:0] RST_BLINK_GAP_MAX  = 16'd900;
    localparam logic [GAP_BITS-1:0] RST_CODE_GAP_MIN   = 16'd1900;
    localparam logic [GAP_BITS-1:0] RST_CODE_GAP_MAX   = 16'd2100;
    localparam logic [GAP_BITS-1:0] RST_WINDOW_TICKS   = 16'd30000;

    typedef struct packed {
        logic                start_req;
        logic [THR_BITS-1:0] sample;
    } t_in_item;

    typedef struct packed {
        logic                  timed_out;
        logic [COUNT_BITS-1:0] blink_count;
        logic [STAT_BITS-1:0]  status;
    } t_out_item;

    typedef struct packed {
        logic [THR_BITS-1:0] dark_threshold;
        logic [GAP_BITS-1:0] blink_gap_min;
        logic [GAP_BITS-1:0] blink_gap_max;
        logic [GAP_BITS-1:0] code_gap_min;
        logic [GAP_BITS-1:0] code_gap_max;
        logic [GAP_BITS-1:0] window_ticks;
    } t_cfg;

    typedef struct packed {
        logic                  window_active;
        logic                  counting;
        logic [COUNT_BITS-1:0] blinks;
        logic [TIMER_BITS-1:0] elapsed;
        logic [TIMER_BITS-1:0] since_dark;
        logic                  dark_ref_valid;
        logic [STAT_BITS-1:0]  status_bits;
    } t_state;

endpackage

`default_nettype wire

// ===== sv/bcd_step.sv =====
// Per-tick decode logic: next decoder state and optional result for one item.
// Depends on bcd_pkg.
`default_nettype none

module bcd_step
    import bcd_pkg::*;
(
    input  wire t_state    i_state,
    input  wire t_in_item  i_item,
    input  wire t_cfg      i_cfg,
    output t_state         o_state,
    output logic           o_res_valid,
    output t_out_item      o_res
);

    logic [TIMER_BITS-1:0] w_limit;

    // Window length clipped to the timer range
    always_comb begin
        if (64'(i_cfg.window_ticks) > TIMER_MAX) begin
            w_limit = TIMER_BITS'(TIMER_MAX);
        end else begin
            w_limit = TIMER_BITS'(i_cfg.window_ticks);
        end
    end

    always_comb begin
        t_state nx;
        logic   proceed;
        logic   in_code;
        logic   in_blink;

        nx          = i_state;
        proceed     = 1'b0;
        in_code     = 1'b0;
        in_blink    = 1'b0;
        o_res_valid = 1'b0;
        o_res       = '0;

        // Window control and timers
        if (i_item.start_req) begin
            nx.window_active  = 1'b1;
            nx.counting       = 1'b0;
            nx.elapsed        = '0;
            nx.since_dark     = '0;
            nx.dark_ref_valid = 1'b0;
            nx.status_bits    = ST_BASE;
            proceed           = 1'b1;
        end else if (!i_state.window_active) begin
            proceed = 1'b0;
        end else if (i_state.elapsed >= w_limit) begin
            nx.window_active  = 1'b0;
            o_res_valid       = 1'b1;
            o_res.timed_out   = 1'b1;
            o_res.blink_count = '0;
            o_res.status      = i_state.status_bits;
        end else begin
            if (!(&i_state.elapsed)) begin
                nx.elapsed = i_state.elapsed + TIMER_BITS'(1);
            end
            if (!(&i_state.since_dark)) begin
                nx.since_dark = i_state.since_dark + TIMER_BITS'(1);
            end
            proceed = 1'b1;
        end

        // Dark sample handling
        if (proceed && !(nx.dark_ref_valid && nx.since_dark < DARK_SPACING)
                && i_item.sample <= i_cfg.dark_threshold) begin
            nx.status_bits = nx.status_bits | ST_DARK;
            in_code  = (64'(i_cfg.code_gap_min) <= 64'(nx.since_dark))
                    && (64'(nx.since_dark) <= 64'(i_cfg.code_gap_max));
            in_blink = (64'(i_cfg.blink_gap_min) <= 64'(nx.since_dark))
                    && (64'(nx.since_dark) <= 64'(i_cfg.blink_gap_max));
            if (nx.dark_ref_valid && in_code && nx.counting) begin
                // Second code gap: report the code and close the window
                if (nx.blinks != COUNT_MAX) begin
                    nx.blinks = nx.blinks + COUNT_BITS'(1);
                end
                nx.window_active  = 1'b0;
                o_res_valid       = 1'b1;
                o_res.timed_out   = 1'b0;
                o_res.blink_count = nx.blinks;
                o_res.status      = nx.status_bits;
            end else begin
                if (nx.dark_ref_valid && in_code) begin
                    nx.counting    = 1'b1;
                    nx.blinks      = '0;
                    nx.status_bits = nx.status_bits | ST_COUNT;
                end else if (nx.dark_ref_valid && in_blink) begin
                    if (nx.blinks != COUNT_MAX) begin
                        nx.blinks = nx.blinks + COUNT_BITS'(1);
                    end
                    nx.status_bits = nx.status_bits | ST_BLINK;
                end
                nx.since_dark     = '0;
                nx.dark_ref_valid = 1'b1;
            end
        end

        o_state = nx;
    end

endmodule

`default_nettype wire

// ===== sv/blink_code_decoder.sv =====
// Top level of the blink code decoder: config registers, input register,
// decoder state and result register. Depends on bcd_pkg and bcd_step.
//
// One item per clock sustained while the output is not stalled; each item
// is one sensor tick. An accepted item is held in the input register until
// bcd_step decodes it, and any result is then registered in the output
// register. The input register takes one more item while a result waits
// on the output; input stalls only when both registers are held by a
// stalled output. Configuration writes take effect on the next edge and
// must only be made while the decoder is idle.
`default_nettype none

module blink_code_decoder
    import bcd_pkg::*;
(
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_ready,
    input  wire t_in_item       i_in_item,
    output logic                o_out_valid,
    input  wire                 i_out_ready,
    output t_out_item           o_out_item,
    input  wire                 i_cfg_we,
    input  wire [IDX_BITS-1:0]  i_cfg_idx,
    input  wire [CFG_BITS-1:0]  i_cfg_data
);

    t_cfg      r_cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    t_state    r_state;
    logic      r_out_valid;
    t_out_item r_out_item;

    t_state    w_state_nx;
    logic      w_res_valid;
    t_out_item w_res;
    logic      w_fire;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dark_threshold <= RST_DARK_THRESHOLD;
            r_cfg.blink_gap_min  <= RST_BLINK_GAP_MIN;
            r_cfg.blink_gap_max  <= RST_BLINK_GAP_MAX;
            r_cfg.code_gap_min   <= RST_CODE_GAP_MIN;
            r_cfg.code_gap_max   <= RST_CODE_GAP_MAX;
            r_cfg.window_ticks   <= RST_WINDOW_TICKS;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_idx))
                CFG_DARK_THRESHOLD: r_cfg.dark_threshold <= i_cfg_data[THR_BITS-1:0];
                CFG_BLINK_GAP_MIN:  r_cfg.blink_gap_min  <= i_cfg_data[GAP_BITS-1:0];
                CFG_BLINK_GAP_MAX:  r_cfg.blink_gap_max  <= i_cfg_data[GAP_BITS-1:0];
                CFG_CODE_GAP_MIN:   r_cfg.code_gap_min   <= i_cfg_data[GAP_BITS-1:0];
                CFG_CODE_GAP_MAX:   r_cfg.code_gap_max   <= i_cfg_data[GAP_BITS-1:0];
                CFG_WINDOW_TICKS:   r_cfg.window_ticks   <= i_cfg_data[GAP_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Decode fires when an item is held and the output slot is free
    assign w_fire     = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_fire;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    bcd_step u_step (
        .i_state     (r_state),
        .i_item      (r_in_item),
        .i_cfg       (r_cfg),
        .o_state     (w_state_nx),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.window_active  <= 1'b0;
            r_state.counting       <= 1'b0;
            r_state.blinks         <= '0;
            r_state.elapsed        <= '0;
            r_state.since_dark     <= '0;
            r_state.dark_ref_valid <= 1'b0;
            r_state.status_bits    <= ST_BASE;
        end else if (w_fire) begin
            r_state <= w_state_nx;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire) begin
            r_out_valid <= w_res_valid;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res_valid) begin
            r_out_item <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // Checks
    a_status_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.status_bits[0])
        else $error("status bit0 cleared");

    a_result_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && w_res_valid) |=> !r_state.window_active)
        else $error("window still open after a result");

    a_no_phantom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_out_valid && !w_fire) |=> !o_out_valid)
        else $error("result appeared without a decode");

    a_stall_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_in_ready |-> (r_in_valid && r_out_valid && !i_out_ready))
        else $error("input stalled with room available");

endmodule

`default_nettype wire

// ===== verif/blink_code_decoder_test.sv =====
// Self-checking testbench for blink_code_decoder: directed table, then random codes.
// A local decoder model predicts each report; results are compared field by field.
// Depends on bcd_pkg and the blink_code_decoder RTL.
module blink_code_decoder_test;
    import bcd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CLK_PERIOD    = 10;
    localparam int ITEM_TARGET   = 1850;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam int HOLD_CYCLES   = 150;
    localparam int SAMPLE_MAX    = (1 << THR_BITS) - 1;

    // Fixed report attached to a directed item
    typedef struct packed {
        logic      on;
        t_out_item rep;
    } t_pin;

    // One row of the directed table: a register write or a tick
    typedef struct packed {
        logic                is_reg;
        t_cfg_idx            idx;
        logic [CFG_BITS-1:0] data;
        t_in_item            item;
        t_pin                pin;
    } t_plan_row;

    logic                i_clk = 1'b0;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_ready;
    t_in_item            i_in_item;
    logic                o_out_valid;
    logic                i_out_ready;
    t_out_item           o_out_item;
    logic                i_cfg_we;
    logic [IDX_BITS-1:0] i_cfg_idx;
    logic [CFG_BITS-1:0] i_cfg_data;

    t_pin        offer_pin;
    t_cfg        cfg_now;
    t_state      dec;
    t_out_item   pending_reports[$];
    t_plan_row   plan[$];
    int unsigned failures      = 0;
    int unsigned item_count    = 0;
    int unsigned cycle_count   = 0;
    int unsigned in_stall_pct  = 25;
    int unsigned out_stall_pct = 25;
    int unsigned hold_off_req  = 0;
    int unsigned stall_pcts[4] = '{0, 10, 30, 60};

    blink_code_decoder dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    function automatic logic roll(input int unsigned pct);
        return $urandom_range(99) < pct;
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int unsigned idle_len();
        return roll(85) ? $urandom_range(3, 1) : $urandom_range(40, 8);
    endfunction

    // Decoder model: advances one tick, returns 1 when the tick yields a report
    function automatic logic predict_tick(input t_in_item it, output t_out_item rep);
        logic [TIMER_BITS-1:0] limit;
        logic [TIMER_BITS-1:0] gap;
        rep  = '0;
        limit = (64'(cfg_now.window_ticks) > TIMER_MAX) ? TIMER_BITS'(TIMER_MAX)
                                                         : TIMER_BITS'(cfg_now.window_ticks);
        if (it.start_req) begin
            dec.window_active  = 1'b1;
            dec.counting       = 1'b0;
            dec.elapsed        = '0;
            dec.since_dark     = '0;
            dec.dark_ref_valid = 1'b0;
            dec.status_bits    = ST_BASE;
        end else begin
            if (!dec.window_active) begin
                return 1'b0;
            end
            // window expired: sample not looked at
            if (dec.elapsed >= limit) begin
                dec.window_active = 1'b0;
                rep = '{timed_out: 1'b1, blink_count: '0, status: dec.status_bits};
                return 1'b1;
            end
            if (dec.elapsed != '1) dec.elapsed = dec.elapsed + TIMER_BITS'(1);
            if (dec.since_dark != '1) dec.since_dark = dec.since_dark + TIMER_BITS'(1);
        end

        // too soon after the last taken dark sample, or not dark at all
        if (dec.dark_ref_valid && dec.since_dark < DARK_SPACING) return 1'b0;
        if (it.sample > cfg_now.dark_threshold) return 1'b0;

        dec.status_bits = dec.status_bits | ST_DARK;
        if (dec.dark_ref_valid) begin
            gap = dec.since_dark;
            // code-gap range wins where the two ranges overlap
            if (cfg_now.code_gap_min <= gap && gap <= cfg_now.code_gap_max) begin
                if (dec.counting) begin
                    if (dec.blinks != COUNT_MAX) dec.blinks = dec.blinks + COUNT_BITS'(1);
                    dec.window_active = 1'b0;
                    rep = '{timed_out: 1'b0, blink_count: dec.blinks, status: dec.status_bits};
                    return 1'b1;
                end
                dec.counting    = 1'b1;
                dec.blinks      = '0;
                dec.status_bits = dec.status_bits | ST_COUNT;
            end else if (cfg_now.blink_gap_min <= gap && gap <= cfg_now.blink_gap_max) begin
                if (dec.blinks != COUNT_MAX) dec.blinks = dec.blinks + COUNT_BITS'(1);
                dec.status_bits = dec.status_bits | ST_BLINK;
            end
        end
        dec.since_dark     = '0;
        dec.dark_ref_valid = 1'b1;
        return 1'b0;
    endfunction

    // Scoreboard: predict on accepted items, compare accepted reports
    always @(posedge i_clk) begin : scoreboard
        t_out_item want;
        t_out_item rep_now;
        logic      got;
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                if (pending_reports.size() == 0) begin
                    $error("report with none pending: timed_out %0d blink_count %0d status %0h",
                           o_out_item.timed_out, o_out_item.blink_count, o_out_item.status);
                    failures++;
                end else begin
                    want = pending_reports.pop_front();
                    if (o_out_item.timed_out !== want.timed_out) begin
                        $error("timed_out: expected %0d, got %0d",
                               want.timed_out, o_out_item.timed_out);
                        failures++;
                    end
                    if (o_out_item.blink_count !== want.blink_count) begin
                        $error("blink_count: expected %0d, got %0d",
                               want.blink_count, o_out_item.blink_count);
                        failures++;
                    end
                    if (o_out_item.status !== want.status) begin
                        $error("status: expected %0h, got %0h", want.status, o_out_item.status);
                        failures++;
                    end
                end
            end
            if (i_in_valid && o_in_ready) begin
                got = predict_tick(i_in_item, rep_now);
                if (offer_pin.on) pending_reports.push_back(offer_pin.rep);
                else if (got) pending_reports.push_back(rep_now);
                item_count++;
            end
        end
    end

    // Run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("blink_code_decoder: mismatch");
            $finish;
        end
    end

    // Report sink: random stalls, plus a long hold-off on request
    initial begin : report_sink
        int unsigned hold_len;
        int unsigned stall;
        i_out_ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_off_req != 0) begin
                hold_len     = hold_off_req;
                hold_off_req = 0;
                i_out_ready <= 1'b0;
                repeat (hold_len) @(posedge i_clk);
            end else if (roll(out_stall_pct)) begin
                stall = idle_len();
                i_out_ready <= 1'b0;
                repeat (stall - 1) @(posedge i_clk);
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    // Offer one item and hold it until accepted; maybe idle afterwards
    task automatic offer_tick(input t_in_item it, input t_pin pin);
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        offer_pin  <= pin;
        do @(posedge i_clk); while (!o_in_ready);
        if (roll(in_stall_pct)) begin
            i_in_valid <= 1'b0;
            repeat (idle_len()) @(posedge i_clk);
        end
    endtask

    task automatic send(input logic start, input logic [THR_BITS-1:0] sample);
        offer_tick('{start_req: start, sample: sample}, '0);
    endtask

    // Stop offering and wait until every report is in and the pipe is empty
    task automatic drain_decoder();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_reports.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_BITS-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        case (idx)
            CFG_DARK_THRESHOLD: cfg_now.dark_threshold = data[THR_BITS-1:0];
            CFG_BLINK_GAP_MIN:  cfg_now.blink_gap_min  = data;
            CFG_BLINK_GAP_MAX:  cfg_now.blink_gap_max  = data;
            CFG_CODE_GAP_MIN:   cfg_now.code_gap_min   = data;
            CFG_CODE_GAP_MAX:   cfg_now.code_gap_max   = data;
            CFG_WINDOW_TICKS:   cfg_now.window_ticks   = data;
            default: ;
        endcase
        @(posedge i_clk);
    endtask

    task automatic apply_config(input t_cfg c);
        drain_decoder();
        write_reg(CFG_DARK_THRESHOLD, CFG_BITS'(c.dark_threshold));
        write_reg(CFG_BLINK_GAP_MIN, c.blink_gap_min);
        write_reg(CFG_BLINK_GAP_MAX, c.blink_gap_max);
        write_reg(CFG_CODE_GAP_MIN, c.code_gap_min);
        write_reg(CFG_CODE_GAP_MAX, c.code_gap_max);
        write_reg(CFG_WINDOW_TICKS, c.window_ticks);
        i_cfg_we <= 1'b0;
    endtask

    // Short gaps and windows keep codes to a few dozen ticks; extremes now and then
    function automatic t_cfg random_config();
        t_cfg c;
        c.dark_threshold = roll(12) ? (roll(50) ? '0 : '1) : THR_BITS'($urandom_range(1022, 1));
        c.blink_gap_min  = GAP_BITS'($urandom_range(6));
        c.blink_gap_max  = c.blink_gap_min + GAP_BITS'($urandom_range(4));
        c.code_gap_min   = GAP_BITS'($urandom_range(12, 2));
        c.code_gap_max   = c.code_gap_min + GAP_BITS'($urandom_range(5));
        c.window_ticks   = GAP_BITS'($urandom_range(160, 8));
        if (roll(10)) c.window_ticks = roll(50) ? '0 : '1;
        case ($urandom_range(11))
            0: c.blink_gap_min = '1;
            1: c.blink_gap_max = '1;
            2: c.blink_gap_max = '0;
            3: c.code_gap_min  = '0;
            4: c.code_gap_min  = '1;
            5: c.code_gap_max  = '1;
            6: c.code_gap_max  = '0;
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [THR_BITS-1:0] dark_sample();
        return THR_BITS'($urandom_range(cfg_now.dark_threshold));
    endfunction

    function automatic logic [THR_BITS-1:0] bright_sample();
        if (cfg_now.dark_threshold == '1) return '1;
        return THR_BITS'($urandom_range(SAMPLE_MAX, cfg_now.dark_threshold + 1));
    endfunction

    // Gap inside [lo, hi], clipped to something short; sometimes deliberately off
    function automatic int unsigned pick_gap(input int unsigned lo, input int unsigned hi);
        int unsigned a;
        int unsigned b;
        a = (lo < 2) ? 2 : lo;
        b = (hi > a + 20) ? a + 20 : hi;
        if (roll(10) || b < a || a > 200) return $urandom_range(30, 2);
        return $urandom_range(b, a);
    endfunction

    // gap-1 bright ticks, then a dark one; a dark right after the last is ignored
    task automatic send_gap(input int unsigned gap);
        for (int unsigned k = 1; k < gap; k++) begin
            if (k == 1 && roll(15)) send(1'b0, dark_sample());
            else send(1'b0, bright_sample());
        end
        send(1'b0, dark_sample());
    endtask

    // Start, reference dark, code gap, some blinks, closing code gap
    task automatic send_code();
        send(1'b1, roll(20) ? dark_sample() : bright_sample());
        repeat ($urandom_range(3)) send(1'b0, bright_sample());
        send(1'b0, dark_sample());
        send_gap(pick_gap(cfg_now.code_gap_min, cfg_now.code_gap_max));
        repeat ($urandom_range(6))
            send_gap(pick_gap(cfg_now.blink_gap_min, cfg_now.blink_gap_max));
        send_gap(pick_gap(cfg_now.code_gap_min, cfg_now.code_gap_max));
    endtask

    function automatic t_plan_row reg_row(input t_cfg_idx idx, input logic [CFG_BITS-1:0] data);
        t_plan_row r;
        r        = '0;
        r.is_reg = 1'b1;
        r.idx    = idx;
        r.data   = data;
        return r;
    endfunction

    function automatic t_plan_row tick_row(input logic start, input logic [THR_BITS-1:0] sample);
        t_plan_row r;
        r      = '0;
        r.item = '{start_req: start, sample: sample};
        return r;
    endfunction

    function automatic t_plan_row pinned_row(input logic start, input logic [THR_BITS-1:0] sample,
                                             input logic timed_out,
                                             input logic [COUNT_BITS-1:0] count,
                                             input logic [STAT_BITS-1:0] status);
        t_plan_row r;
        r     = tick_row(start, sample);
        r.pin = '{on: 1'b1, rep: '{timed_out: timed_out, blink_count: count, status: status}};
        return r;
    endfunction

    initial begin : stimulus
        t_cfg        c;
        int unsigned phase;
        i_rst_n    <= 1'b0;
        i_in_valid <= 1'b0;
        i_in_item  <= '0;
        offer_pin  <= '0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= CFG_DARK_THRESHOLD;
        i_cfg_data <= '0;
        cfg_now = '{dark_threshold: RST_DARK_THRESHOLD, blink_gap_min: RST_BLINK_GAP_MIN,
                    blink_gap_max: RST_BLINK_GAP_MAX, code_gap_min: RST_CODE_GAP_MIN,
                    code_gap_max: RST_CODE_GAP_MAX, window_ticks: RST_WINDOW_TICKS};
        dec = '0;
        dec.status_bits = ST_BASE;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a full code with too-soon and threshold-edge samples, a tick on a
        // closed window, two timeouts with zero window, overlapping ranges at max window
        plan = '{
            reg_row(CFG_DARK_THRESHOLD, 16'd100), reg_row(CFG_BLINK_GAP_MIN, 16'd2),
            reg_row(CFG_BLINK_GAP_MAX, 16'd2),    reg_row(CFG_CODE_GAP_MIN, 16'd3),
            reg_row(CFG_CODE_GAP_MAX, 16'd4),     reg_row(CFG_WINDOW_TICKS, 16'd12),
            tick_row(1'b1, 10'd1023), tick_row(1'b0, 10'd0),   tick_row(1'b0, 10'd0),
            tick_row(1'b0, 10'd1023), tick_row(1'b0, 10'd100), tick_row(1'b0, 10'd101),
            tick_row(1'b0, 10'd50),   tick_row(1'b0, 10'd1023), tick_row(1'b0, 10'd0),
            tick_row(1'b0, 10'd1023), tick_row(1'b0, 10'd1023), tick_row(1'b0, 10'd1023),
            pinned_row(1'b0, 10'd0, 1'b0, 8'd3, ST_BASE | ST_DARK | ST_COUNT | ST_BLINK),
            tick_row(1'b0, 10'd0),
            reg_row(CFG_WINDOW_TICKS, 16'd0),
            tick_row(1'b1, 10'd1023),
            pinned_row(1'b0, 10'd0, 1'b1, 8'd0, ST_BASE),
            tick_row(1'b1, 10'd0),
            pinned_row(1'b0, 10'd1023, 1'b1, 8'd0, ST_BASE | ST_DARK),
            reg_row(CFG_BLINK_GAP_MAX, 16'd3), reg_row(CFG_CODE_GAP_MIN, 16'd2),
            reg_row(CFG_CODE_GAP_MAX, 16'd3),  reg_row(CFG_WINDOW_TICKS, 16'hFFFF),
            tick_row(1'b1, 10'd0), tick_row(1'b0, 10'd1023), tick_row(1'b0, 10'd0),
            tick_row(1'b0, 10'd1023),
            pinned_row(1'b0, 10'd0, 1'b0, 8'd1, ST_BASE | ST_DARK | ST_COUNT)
        };
        foreach (plan[k]) begin
            if (plan[k].is_reg) begin
                if (!i_cfg_we) drain_decoder();
                write_reg(plan[k].idx, plan[k].data);
            end else begin
                i_cfg_we <= 1'b0;
                offer_tick(plan[k].item, plan[k].pin);
            end
        end

        // Random phases, each under its own settings
        phase = 0;
        while (item_count < ITEM_TARGET) begin
            in_stall_pct  = stall_pcts[$urandom_range(3)];
            out_stall_pct = stall_pcts[$urandom_range(3)];
            case (phase)
                1: begin
                    // blink count runs into saturation
                    c = '{dark_threshold: 10'd500, blink_gap_min: 16'd2, blink_gap_max: 16'd2,
                          code_gap_min: 16'd3, code_gap_max: 16'd3, window_ticks: 16'hFFFF};
                    apply_config(c);
                    send(1'b1, bright_sample());
                    send(1'b0, dark_sample());
                    send_gap(3);
                    repeat (260) send_gap(2);
                    send_gap(3);
                end
                3: begin
                    // zero window gives a report every other tick; sink holds off meanwhile
                    c = random_config();
                    c.window_ticks = '0;
                    apply_config(c);
                    in_stall_pct = 0;
                    hold_off_req = HOLD_CYCLES;
                    repeat (40) begin
                        send(1'b1, THR_BITS'($urandom_range(SAMPLE_MAX)));
                        send(1'b0, THR_BITS'($urandom_range(SAMPLE_MAX)));
                    end
                end
                default: begin
                    apply_config(random_config());
                    repeat ($urandom_range(8, 3)) begin
                        if (roll(15)) begin
                            repeat ($urandom_range(20, 4))
                                send(roll(10), THR_BITS'($urandom_range(SAMPLE_MAX)));
                        end else begin
                            send_code();
                        end
                    end
                end
            endcase
            phase++;
        end

        drain_decoder();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_reports.size() == 0) begin
            $display("blink_code_decoder: match");
        end else begin
            $display("blink_code_decoder: mismatch");
        end
        $finish;
    end

endmodule
